@@ hw/rtl/lcwm_pkg.sv @@
// lcwm_pkg: shared types and fixed constants for the card window mapper.
// No dependencies; imported by the mapper core and its checker.
package lcwm_pkg;

    // Sequencer states of the mapper core.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lcwm_state_t;

    // Operation codes of an input word.
    typedef enum logic {
        OP_MAP     = 1'b0,
        OP_DISABLE = 1'b1
    } lcwm_op_t;

    // Configuration register file: host base of windows 0..3.
    localparam int NUM_CFG_REGS = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int HOST_BASE_W  = 24;

    // Result word field widths.
    localparam int WINDOW_INDEX_W = 2;
    localparam int OFFREG_W       = 13;
    localparam int OFFSET_W       = 13;
    localparam int ENABLE_MASK_W  = 4;

    // Card offset register arithmetic: 25-bit difference, shifted right by 12.
    localparam int OFFREG_DIFF_W = 25;
    localparam int OFFREG_SHIFT  = 12;

    // LRU time stamps and the use counter.
    localparam int STAMP_W = 32;

endpackage

@@ hw/rtl/lru_card_window_mapper_core.sv @@
// lru_card_window_mapper_core: maps card addresses onto LRU-managed host windows.
// Depends on lcwm_pkg (state enum, op codes, field widths).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall | op, card_address, attribute_space
//  out     | source    | out_valid/out_stall | window_index, hit, card_offset_reg,
//          |           |                     | offset_in_window, enable_mask
//  cfg     | sink      | cfg_we              | cfg_index, cfg_data (host base 0..3)
//
// A map word is captured, then scanned window by window through the shared compare
// unit, then updated and registered. A disable word skips the scan.
// Reset clears all windows, stamps, the use counter and the host bases.
// A new word is taken while the previous result still waits in the output
// register; the update step holds until that register is free.
module lru_card_window_mapper_core #(
    parameter int NUM_WINDOWS       = 4,
    parameter int WINDOW_BITS       = 13,
    parameter int CARD_ADDRESS_BITS = 26
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [lcwm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lcwm_pkg::HOST_BASE_W-1:0]     cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic [CARD_ADDRESS_BITS-1:0]         card_address,
    input  logic                                 attribute_space,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lcwm_pkg::WINDOW_INDEX_W-1:0]  window_index,
    output logic                                 hit,
    output logic [lcwm_pkg::OFFREG_W-1:0]        card_offset_reg,
    output logic [lcwm_pkg::OFFSET_W-1:0]        offset_in_window,
    output logic [lcwm_pkg::ENABLE_MASK_W-1:0]   enable_mask
);
    import lcwm_pkg::*;

    // window index width; at least one bit even for a single window
    localparam int IDX_W   = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int CHUNK_W = CARD_ADDRESS_BITS - WINDOW_BITS;
    // padded widths so the fixed-width result fields can be cut out
    localparam int SELP_W  = (IDX_W > WINDOW_INDEX_W) ? IDX_W : WINDOW_INDEX_W;
    localparam int MASKP_W = (NUM_WINDOWS > ENABLE_MASK_W) ? NUM_WINDOWS : ENABLE_MASK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WINDOWS - 1);

    // sequencer
    lcwm_state_t state_reg, state_next;

    // configuration
    logic [HOST_BASE_W-1:0] host_base_reg [NUM_CFG_REGS];

    // window table (small; one scan read port, one update write port)
    logic [NUM_WINDOWS-1:0] enables_reg;
    logic [CHUNK_W-1:0]     win_chunk_reg [NUM_WINDOWS];
    logic                   win_attr_reg  [NUM_WINDOWS];
    logic [STAMP_W-1:0]     win_stamp_reg [NUM_WINDOWS];
    logic [STAMP_W-1:0]     use_counter_reg;

    // captured word
    logic                         op_q_reg;
    logic [CARD_ADDRESS_BITS-1:0] addr_q_reg;
    logic                         attr_q_reg;

    // scan state
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   min_idx_reg;
    logic [STAMP_W-1:0] min_stamp_reg;

    // output register
    logic                      out_valid_reg;
    logic [WINDOW_INDEX_W-1:0] window_index_reg;
    logic                      hit_reg;
    logic [OFFREG_W-1:0]       card_offset_reg_reg;
    logic [OFFSET_W-1:0]       offset_in_window_reg;
    logic [ENABLE_MASK_W-1:0]  enable_mask_reg;

    // control
    logic accept;
    logic scan_step;
    logic do_update;
    logic out_free;

    // datapath
    logic [CHUNK_W-1:0]       chunk_q;
    logic                     scan_match;
    logic                     scan_less;
    logic [IDX_W-1:0]         sel;
    logic [SELP_W-1:0]        sel_pad;
    logic [HOST_BASE_W-1:0]   sel_base;
    logic [OFFREG_DIFF_W-1:0] offreg_diff;
    logic [NUM_WINDOWS-1:0]   enables_next;
    logic [MASKP_W-1:0]       mask_pad;

    // ---------------------------------------------------------------- FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        scan_step  = 1'b0;
        do_update  = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    accept     = 1'b1;
                    // disable words skip the scan
                    state_next = (op == OP_DISABLE) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // table update and result load happen together, once
                if (out_free)
                begin
                    do_update  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    assign chunk_q = addr_q_reg[CARD_ADDRESS_BITS-1:WINDOW_BITS];

    // shared compare unit: one window per cycle
    assign scan_match = enables_reg[idx_reg] && (win_attr_reg[idx_reg] == attr_q_reg)
                        && (win_chunk_reg[idx_reg] == chunk_q);
    // strict less keeps the lowest index on equal stamps
    assign scan_less  = (idx_reg == '0) || (win_stamp_reg[idx_reg] < min_stamp_reg);

    assign sel      = hit_found_reg ? hit_idx_reg : min_idx_reg;
    assign sel_pad  = SELP_W'(sel);
    // windows beyond the register file keep a zero host base
    assign sel_base = (int'(sel) < NUM_CFG_REGS) ?
                      host_base_reg[sel_pad[CFG_INDEX_W-1:0]] : '0;

    // aligned chunk address minus host base, kept to 25 bits
    assign offreg_diff = OFFREG_DIFF_W'({chunk_q, {WINDOW_BITS{1'b0}}})
                         - OFFREG_DIFF_W'(sel_base);

    always_comb
    begin
        if (op_q_reg == OP_DISABLE)
        begin
            enables_next = '0;
        end
        else if (hit_found_reg)
        begin
            enables_next = enables_reg;
        end
        else
        begin
            enables_next = enables_reg | (NUM_WINDOWS'(1) << sel);
        end
    end

    assign mask_pad = MASKP_W'(enables_next);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG_REGS; i++)
            begin
                host_base_reg[i] <= '0;
            end
        end
        else if (cfg_we && (int'(cfg_index) < NUM_WINDOWS))
        begin
            host_base_reg[cfg_index] <= cfg_data;
        end
    end

    // window table, stamps and use counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg     <= '0;
            use_counter_reg <= '0;
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                win_chunk_reg[i] <= '0;
                win_attr_reg[i]  <= 1'b0;
                win_stamp_reg[i] <= '0;
            end
        end
        else if (do_update)
        begin
            enables_reg <= enables_next;
            if (op_q_reg == OP_MAP)
            begin
                if (!hit_found_reg)
                begin
                    win_chunk_reg[sel] <= chunk_q;
                    win_attr_reg[sel]  <= attr_q_reg;
                end
                win_stamp_reg[sel] <= use_counter_reg;
                use_counter_reg    <= use_counter_reg + 1'b1;
            end
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
        end
        else if (accept)
        begin
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
        end
        else if (scan_step)
        begin
            if (idx_reg != LAST_IDX)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (scan_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
        end
    end

    // captured word and scan payload: first hit and running minimum
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_q_reg   <= op;
            addr_q_reg <= card_address;
            attr_q_reg <= attribute_space;
        end
        if (scan_step)
        begin
            if (scan_match && !hit_found_reg)
            begin
                hit_idx_reg <= idx_reg;
            end
            if (scan_less)
            begin
                min_idx_reg   <= idx_reg;
                min_stamp_reg <= win_stamp_reg[idx_reg];
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_update)
        begin
            if (op_q_reg == OP_DISABLE)
            begin
                window_index_reg     <= '0;
                hit_reg              <= 1'b0;
                card_offset_reg_reg  <= '0;
                offset_in_window_reg <= '0;
            end
            else
            begin
                window_index_reg     <= sel_pad[WINDOW_INDEX_W-1:0];
                hit_reg              <= hit_found_reg;
                card_offset_reg_reg  <= hit_found_reg ? '0 :
                                        offreg_diff[OFFREG_DIFF_W-1:OFFREG_SHIFT];
                offset_in_window_reg <= OFFSET_W'(addr_q_reg[WINDOW_BITS-1:0]);
            end
            enable_mask_reg <= mask_pad[ENABLE_MASK_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign window_index     = window_index_reg;
    assign hit              = hit_reg;
    assign card_offset_reg  = card_offset_reg_reg;
    assign offset_in_window = offset_in_window_reg;
    assign enable_mask      = enable_mask_reg;

endmodule

@@ hw/rtl/lcwm_checker.sv @@
// lcwm_checker: port-level assertions for lru_card_window_mapper_core, and its bind.
// Depends on lcwm_pkg for field widths.
module lcwm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [lcwm_pkg::WINDOW_INDEX_W-1:0] window_index,
    input logic                                hit,
    input logic [lcwm_pkg::OFFREG_W-1:0]       card_offset_reg,
    input logic [lcwm_pkg::ENABLE_MASK_W-1:0]  enable_mask
);
    import lcwm_pkg::*;

    // one word at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a word");

    // a hit writes no offset register
    a_hit_no_offreg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> card_offset_reg == '0)
        else $error("hit word carries a card offset value");

    // the hitting window must be enabled in the reported mask
    a_hit_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> enable_mask[window_index])
        else $error("hit on a window that is not enabled");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(window_index) && $stable(hit)
            && $stable(card_offset_reg) && $stable(enable_mask))
        else $error("stalled output word changed");

endmodule

bind lru_card_window_mapper_core lcwm_checker u_lcwm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .window_index    (window_index),
    .hit             (hit),
    .card_offset_reg (card_offset_reg),
    .enable_mask     (enable_mask)
);
